// ===== rtl/core/gcl_pkg.sv =====
// gcl_pkg: shared constants and controller/datapath command and status types
// for the GCD/LCM unit. No dependencies.
`default_nettype none
package gcl_pkg;

    localparam int DATA_WIDTH_DEFAULT = 32;
    localparam int OPERAND_WIDTH      = 32;
    localparam int DIVISOR_WIDTH      = 32;
    localparam int MULTIPLE_WIDTH     = 63;
    localparam int PRODUCT_EXT_WIDTH  = 64;

    typedef struct packed {
        logic load;
        logic gcd_div_start;
        logic lcm_div_start;
        logic div_step;
        logic swap;
        logic mul;
        logic write_out;
    } gcl_cmd_t;

    typedef struct packed {
        logic y_zero;
        logic div_last;
    } gcl_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/gcl_if.sv =====
// gcl_if: valid/ready channel interfaces for operand requests and results.
// Depends on gcl_pkg for field widths.
`default_nettype none
interface gcl_req_if
    import gcl_pkg::*;
();
    logic                            valid;
    logic                            ready;
    logic signed [OPERAND_WIDTH-1:0] first_value;
    logic signed [OPERAND_WIDTH-1:0] second_value;

    modport source (output valid, output first_value, output second_value, input ready);
    modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface gcl_rsp_if
    import gcl_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [DIVISOR_WIDTH-1:0]  divisor_result;
    logic [MULTIPLE_WIDTH-1:0] multiple_result;

    modport source (output valid, output divisor_result, output multiple_result, input ready);
    modport sink   (input valid, input divisor_result, input multiple_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gcl_datapath.sv =====
// gcl_datapath: operand magnitudes, Euclid registers, shared restoring
// divider, LCM multiplier and result registers. Depends on gcl_pkg.
`default_nettype none
module gcl_datapath
    import gcl_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  wire logic                      clk,
    input  wire gcl_cmd_t                  cmd,
    output gcl_status_t                    status,
    input  wire logic [OPERAND_WIDTH-1:0]  first_value,
    input  wire logic [OPERAND_WIDTH-1:0]  second_value,
    output logic [DIVISOR_WIDTH-1:0]       divisor_result,
    output logic [MULTIPLE_WIDTH-1:0]      multiple_result
);

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     ma_reg, mb_reg, x_reg, y_reg, d_reg, quo_reg;
    logic [W:0]       rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [2*W-1:0]   prod_reg;
    logic [DIVISOR_WIDTH-1:0]  gcd_out_reg;
    logic [MULTIPLE_WIDTH-1:0] lcm_out_reg;

    logic [W-1:0] mag_a, mag_b;
    logic [W:0]   rem_sh, rem_diff;
    logic [PRODUCT_EXT_WIDTH-1:0] prod_ext;

    function automatic logic [W-1:0] magnitude(input logic [OPERAND_WIDTH-1:0] raw);
        logic [W-1:0] v;
        v = raw[W-1:0];
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    assign mag_a    = magnitude(first_value);
    assign mag_b    = magnitude(second_value);
    assign rem_sh   = {rem_reg[W-1:0], quo_reg[W-1]};
    assign rem_diff = rem_sh - {1'b0, d_reg};
    assign prod_ext = PRODUCT_EXT_WIDTH'(prod_reg);

    assign status.y_zero   = (y_reg == '0);
    assign status.div_last = (cnt_reg == CNT_W'(W - 1));

    assign divisor_result  = gcd_out_reg;
    assign multiple_result = lcm_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ma_reg <= mag_a;
            mb_reg <= mag_b;
            x_reg  <= mag_a;
            y_reg  <= mag_b;
        end
        if (cmd.swap)
        begin
            x_reg <= y_reg;
            y_reg <= rem_reg[W-1:0];
        end
        if (cmd.gcd_div_start)
        begin
            quo_reg <= x_reg;
            d_reg   <= y_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.lcm_div_start)
        begin
            quo_reg <= ma_reg;
            d_reg   <= x_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_diff[W])
            begin
                rem_reg <= rem_diff;
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.mul)
        begin
            prod_reg <= quo_reg * mb_reg;
        end
        if (cmd.write_out)
        begin
            gcd_out_reg <= DIVISOR_WIDTH'(x_reg);
            lcm_out_reg <= prod_ext[MULTIPLE_WIDTH-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/gcl_controller.sv =====
// gcl_controller: sequencer for Euclid steps, LCM divide and multiply, and
// result handshake. Depends on gcl_pkg.
`default_nettype none
module gcl_controller
    import gcl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire gcl_status_t status,
    output gcl_cmd_t         cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_GDIV  = 3'd2;
    localparam logic [2:0] S_SWAP  = 3'd3;
    localparam logic [2:0] S_LDIV  = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.y_zero)
                begin
                    cmd.lcm_div_start = 1'b1;
                    state_next        = S_LDIV;
                end
                else
                begin
                    cmd.gcd_div_start = 1'b1;
                    state_next        = S_GDIV;
                end
            end
            S_GDIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                cmd.swap   = 1'b1;
                state_next = S_CHECK;
            end
            S_LDIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.write_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.write_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/gcd_lcm_unit.sv =====
// gcd_lcm_unit: top level joining controller and datapath.
// Depends on gcl_pkg, gcl_if, gcl_controller, gcl_datapath.
//
// Usage:
//   req channel carries first_value and second_value (signed, low DATA_WIDTH
//   bits used, bit DATA_WIDTH-1 is the sign). rsp channel returns
//   divisor_result (gcd of magnitudes) and multiple_result (lcm).
//   One request at a time: req.ready is high only while the sequencer idles.
//   Each request runs the Euclid remainder steps (up to about 46 at
//   32 bits), each done by the shared bit-serial restoring divider at one
//   quotient bit per cycle; the LCM then takes one more divide and one
//   registered multiply.
//   The result sits in an output register; a new request is taken while it
//   waits. If rsp.ready stays low, the next result is held back until the
//   pending one is taken.
//   Reset clears the sequencer and rsp.valid; the datapath registers are not reset.
`default_nettype none
module gcd_lcm_unit
    import gcl_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gcl_req_if.sink   req,
    gcl_rsp_if.source rsp
);

    gcl_cmd_t    cmd;
    gcl_status_t status;

    gcl_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    gcl_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk             (clk),
        .cmd             (cmd),
        .status          (status),
        .first_value     (req.first_value),
        .second_value    (req.second_value),
        .divisor_result  (rsp.divisor_result),
        .multiple_result (rsp.multiple_result)
    );

endmodule
`default_nettype wire

// ===== rtl/core/gcl_checker.sv =====
// gcl_checker: port-level assertions for gcd_lcm_unit, bound to the top.
// Depends on gcl_pkg.
`default_nettype none
module gcl_checker
    import gcl_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      req_valid,
    input wire logic                      req_ready,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_ready,
    input wire logic [DIVISOR_WIDTH-1:0]  divisor_result,
    input wire logic [MULTIPLE_WIDTH-1:0] multiple_result
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp.valid dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(divisor_result) && $stable(multiple_result))
        else $error("rsp payload changed while stalled");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req.ready high right after a request was taken");

    a_zero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (divisor_result == '0) |-> (multiple_result == '0))
        else $error("nonzero lcm with zero gcd");

endmodule

bind gcd_lcm_unit gcl_checker u_gcl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .divisor_result  (rsp.divisor_result),
    .multiple_result (rsp.multiple_result)
);
`default_nettype wire
